// File: src/etcf_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helper functions of the datagram frame builder
package etcf_pkg;

  localparam int MIN_FRAME  = 46;
  localparam int MAX_FRAME  = 1500;
  localparam int HDR_BYTES  = 14;
  localparam int LEN_W      = 11;
  localparam int BODY_BYTES = 12;
  localparam int BODY_W     = BODY_BYTES * 8;
  localparam int BCNT_W     = $clog2(BODY_BYTES + 1);
  localparam int TAIL_W     = $clog2(MIN_FRAME - HDR_BYTES + 3);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic [2:0] KIND_NPRD = 3'd0;
  localparam logic [2:0] KIND_NPWR = 3'd1;
  localparam logic [2:0] KIND_APRD = 3'd2;
  localparam logic [2:0] KIND_APWR = 3'd3;
  localparam logic [2:0] KIND_BRD  = 3'd4;
  localparam logic [2:0] KIND_BWR  = 3'd5;
  localparam logic [2:0] KIND_LRW  = 3'd6;
  localparam logic [2:0] KIND_BAD  = 3'd7;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LONG = 2'd1,
    ST_SEQ  = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]       op_kind;
    logic [15:0]      station;
    logic [31:0]      mem_offset;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       payload_byte;
  } item_t;

  // one job: body words shifted out lowest first, then tail_cnt zero words
  typedef struct packed {
    logic [BODY_W-1:0] body;
    logic [BCNT_W-1:0] body_cnt;
    status_t           status;
    logic [TAIL_W-1:0] tail_cnt;
  } job_t;

  function automatic logic [7:0] type_code(input logic [2:0] kind);
    logic [7:0] code;
    case (kind)
      KIND_NPRD: code = 8'd4;
      KIND_NPWR: code = 8'd5;
      KIND_APRD: code = 8'd1;
      KIND_APWR: code = 8'd2;
      KIND_BRD:  code = 8'd7;
      KIND_BWR:  code = 8'd8;
      KIND_LRW:  code = 8'd12;
      default:   code = 8'd0;
    endcase
    return code;
  endfunction

  // working counter plus padding up to the minimum frame size
  function automatic logic [TAIL_W-1:0] tail_count(input logic [LEN_W-1:0] len);
    logic [LEN_W:0] total;
    logic [LEN_W:0] pad;
    total = {1'b0, len} + (LEN_W+1)'(HDR_BYTES);
    pad   = (LEN_W+1)'(MIN_FRAME) - total;
    if (total < (LEN_W+1)'(MIN_FRAME)) begin
      return TAIL_W'(pad) + TAIL_W'(2);
    end
    return TAIL_W'(2);
  endfunction

endpackage

// File: src/etcf_decode.sv
`timescale 1ns / 1ps
// frame tracking state and per-word job decode
module etcf_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 command,
  input  etcf_pkg::item_t      item,
  output etcf_pkg::job_t       job
);

  logic [7:0]                 next_index;
  logic                       in_frame;
  logic                       is_read;
  logic [etcf_pkg::LEN_W-1:0] held_length;
  logic [etcf_pkg::LEN_W-1:0] bytes_left;

  logic [7:0]                 next_index_next;
  logic                       in_frame_next;
  logic                       is_read_next;
  logic [etcf_pkg::LEN_W-1:0] held_length_next;
  logic [etcf_pkg::LEN_W-1:0] bytes_left_next;

  logic [etcf_pkg::LEN_W:0]   len_total;
  logic [etcf_pkg::LEN_W-1:0] len_hdr;
  logic [15:0]                frame_hdr;
  logic [31:0]                addr;

  always_comb begin
    len_total = {1'b0, item.payload_length} + (etcf_pkg::LEN_W+1)'(etcf_pkg::HDR_BYTES);
    len_hdr   = item.payload_length + etcf_pkg::LEN_W'(12);
    frame_hdr = {5'b00010, len_hdr};
    case (item.op_kind)
      etcf_pkg::KIND_NPRD, etcf_pkg::KIND_NPWR:
        addr = {item.mem_offset[15:0], item.station};
      etcf_pkg::KIND_APRD, etcf_pkg::KIND_APWR:
        addr = {item.mem_offset[15:0], 16'(16'd0 - item.station)};
      etcf_pkg::KIND_BRD, etcf_pkg::KIND_BWR:
        addr = {item.mem_offset[15:0], 16'd0};
      default:
        addr = item.mem_offset;
    endcase

    next_index_next  = next_index;
    in_frame_next    = in_frame;
    is_read_next     = is_read;
    held_length_next = held_length;
    bytes_left_next  = bytes_left;

    job.body     = '0;
    job.body_cnt = etcf_pkg::BCNT_W'(1);
    job.status   = etcf_pkg::ST_OK;
    job.tail_cnt = '0;

    if (command == etcf_pkg::CMD_START) begin
      if (in_frame || item.op_kind == etcf_pkg::KIND_BAD) begin
        job.status = etcf_pkg::ST_SEQ;
      end else if (len_total > (etcf_pkg::LEN_W+1)'(etcf_pkg::MAX_FRAME)) begin
        job.status = etcf_pkg::ST_LONG;
      end else begin
        job.body     = {16'h0000, 5'b00000, item.payload_length, addr, next_index,
                        etcf_pkg::type_code(item.op_kind), frame_hdr};
        job.body_cnt = etcf_pkg::BCNT_W'(etcf_pkg::BODY_BYTES);
        next_index_next  = next_index + 8'd1;
        is_read_next     = (item.op_kind == etcf_pkg::KIND_NPRD) ||
                           (item.op_kind == etcf_pkg::KIND_APRD) ||
                           (item.op_kind == etcf_pkg::KIND_BRD);
        held_length_next = item.payload_length;
        bytes_left_next  = item.payload_length;
        if (item.payload_length == '0) begin
          job.tail_cnt  = etcf_pkg::tail_count(item.payload_length);
          in_frame_next = 1'b0;
        end else begin
          in_frame_next = 1'b1;
        end
      end
    end else begin
      if (!in_frame) begin
        job.status = etcf_pkg::ST_SEQ;
      end else begin
        job.body[7:0]   = is_read ? 8'h00 : item.payload_byte;
        bytes_left_next = bytes_left - etcf_pkg::LEN_W'(1);
        if (bytes_left == etcf_pkg::LEN_W'(1)) begin
          job.tail_cnt  = etcf_pkg::tail_count(held_length);
          in_frame_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_index  <= '0;
      in_frame    <= 1'b0;
      is_read     <= 1'b0;
      held_length <= '0;
      bytes_left  <= '0;
    end else if (accept) begin
      next_index  <= next_index_next;
      in_frame    <= in_frame_next;
      is_read     <= is_read_next;
      held_length <= held_length_next;
      bytes_left  <= bytes_left_next;
    end
  end

endmodule

// File: src/etcf_emitter.sv
`timescale 1ns / 1ps
// job register that serializes frame words into the output register
module etcf_emitter (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  etcf_pkg::job_t job_in,
  output logic           ready,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic           m_tlast,
  output logic [1:0]     m_tuser
);

  etcf_pkg::job_t job;
  logic           busy;
  logic           emit;
  logic           last;
  logic           in_body;

  always_comb begin
    in_body = job.body_cnt != '0;
    busy    = in_body || (job.tail_cnt != '0);
    emit    = busy && (!m_tvalid || m_tready);
    last    = (job.body_cnt == etcf_pkg::BCNT_W'(1) && job.tail_cnt == '0) ||
              (!in_body && job.tail_cnt == etcf_pkg::TAIL_W'(1));
    ready   = !busy || (emit && last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job.body_cnt <= '0;
      job.tail_cnt <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (load) begin
        job.body_cnt <= job_in.body_cnt;
        job.tail_cnt <= job_in.tail_cnt;
      end else if (emit) begin
        if (in_body) begin
          job.body_cnt <= job.body_cnt - etcf_pkg::BCNT_W'(1);
        end else begin
          job.tail_cnt <= job.tail_cnt - etcf_pkg::TAIL_W'(1);
        end
      end
    end
    if (load) begin
      job.body   <= job_in.body;
      job.status <= job_in.status;
    end else if (emit && in_body) begin
      job.body <= {8'h00, job.body[etcf_pkg::BODY_W-1:8]};
    end
    if (emit) begin
      m_tdata <= in_body ? job.body[7:0] : 8'h00;
      m_tlast <= !in_body && job.tail_cnt == etcf_pkg::TAIL_W'(1);
      m_tuser <= in_body ? job.status : etcf_pkg::ST_OK;
    end
  end

endmodule

// File: src/ethercat_datagram_tx_framer.sv
`timescale 1ns / 1ps
// top level of the single-datagram frame builder
//
// Each input word is decoded into a job held in the job register, which then feeds
// one frame word per cycle into the output register unless m_tready stalls it. A
// payload word makes one output word, so payload flows at one word per clock when
// not stalled. A start word makes the 12 header words, and the word that closes a
// frame (last payload word, or a start with zero length) adds the 2-word working
// counter plus zero padding up to the 46-byte minimum; the next input word is taken
// in the cycle the last of these moves to the output register. Error words (too
// long, out of sequence) make one word with a nonzero status in tuser. The output
// register lets a new word be taken while a finished one still waits on m_tready.
module ethercat_datagram_tx_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // op_kind, station, mem_offset, payload_length, payload_byte, 2 unused bits
  input  logic [71:0] s_tdata,
  // command
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_byte
  output logic [7:0]  m_tdata,
  // frame_end
  output logic        m_tlast,
  // status
  output logic [1:0]  m_tuser
);

  etcf_pkg::item_t item;
  etcf_pkg::job_t  job;
  logic            accept;
  logic            ready;

  assign item.op_kind        = s_tdata[2:0];
  assign item.station        = s_tdata[18:3];
  assign item.mem_offset     = s_tdata[50:19];
  assign item.payload_length = s_tdata[61:51];
  assign item.payload_byte   = s_tdata[69:62];

  assign s_tready = ready;
  assign accept   = s_tvalid && ready;

  etcf_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .command (s_tuser),
    .item    (item),
    .job     (job)
  );

  etcf_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .job_in   (job),
    .ready    (ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

`ifndef SYNTHESIS
  a_last_is_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == etcf_pkg::ST_OK)
    else $error("frame end word carries an error status");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != etcf_pkg::ST_OK |-> m_tdata == 8'h00 && !m_tlast)
    else $error("error word carries data or frame end");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");
`endif

endmodule
